[rtl/hcl_pkg.sv]
package hcl_pkg;

   // Defaults for the top level parameters
   localparam int ALPHABET_SIZE_DEF = 64;
   localparam int FREQ_BITS_DEF     = 24;

   // Fixed result field widths
   localparam int SYM_W    = 6;
   localparam int LEN_W    = 6;
   localparam int SUM_W    = 36;
   localparam int STATUS_W = 2;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_FREQ = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_MERGE_SCAN,
      ST_MERGE_END,
      ST_MERGE_W1,
      ST_MERGE_W2,
      ST_DEPTH_ROOT,
      ST_DEPTH_P,
      ST_DEPTH_D,
      ST_DEPTH_W,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_ERR
   } state_type;

endpackage

[rtl/hcl_if.sv]
interface hcl_req_if #(
   parameter int FREQ_BITS = hcl_pkg::FREQ_BITS_DEF
);
   logic                 valid;
   logic                 ready;
   logic [FREQ_BITS-1:0] symbol_freq;
   logic                 last_symbol;

   modport source (output valid, output symbol_freq, output last_symbol, input ready);
   modport sink   (input valid, input symbol_freq, input last_symbol, output ready);
endinterface

interface hcl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hcl_pkg::SYM_W-1:0]     symbol_index;
   logic [hcl_pkg::LEN_W-1:0]     code_length;
   logic [hcl_pkg::SUM_W-1:0]     path_length_sum;
   logic [hcl_pkg::STATUS_W-1:0]  status;
   logic                          last_result;

   modport source (output valid, output symbol_index, output code_length,
                   output path_length_sum, output status, output last_result,
                   input ready);
   modport sink   (input valid, input symbol_index, input code_length,
                   input path_length_sum, input status, input last_result,
                   output ready);
endinterface

[rtl/hcl_min2.sv]
module hcl_min2 #(
   parameter int IDX_W = 7,
   parameter int WGT_W = 30
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             en,
   input  logic [IDX_W-1:0] idx,
   input  logic [WGT_W-1:0] weight,
   output logic [IDX_W-1:0] first_idx,
   output logic [IDX_W-1:0] second_idx,
   output logic [WGT_W-1:0] first_wgt,
   output logic [WGT_W-1:0] second_wgt,
   output logic             both_found
);

   logic             f1_ff, f1_in, f2_ff, f2_in;
   logic [IDX_W-1:0] a1_ff, a1_in, a2_ff, a2_in;
   logic [WGT_W-1:0] w1_ff, w1_in, w2_ff, w2_in;

   // Keep the two lightest entries; strict compare leaves ties to the earlier index
   always_comb begin
      f1_in = f1_ff;
      f2_in = f2_ff;
      a1_in = a1_ff;
      a2_in = a2_ff;
      w1_in = w1_ff;
      w2_in = w2_ff;
      if (clear) begin
         f1_in = 1'b0;
         f2_in = 1'b0;
      end else if (en) begin
         if (!f1_ff || weight < w1_ff) begin
            f2_in = f1_ff;
            a2_in = a1_ff;
            w2_in = w1_ff;
            f1_in = 1'b1;
            a1_in = idx;
            w1_in = weight;
         end else if (!f2_ff || weight < w2_ff) begin
            f2_in = 1'b1;
            a2_in = idx;
            w2_in = weight;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_ff <= 1'b0;
         f2_ff <= 1'b0;
      end else begin
         f1_ff <= f1_in;
         f2_ff <= f2_in;
      end
      a1_ff <= a1_in;
      a2_ff <= a2_in;
      w1_ff <= w1_in;
      w2_ff <= w2_in;
   end

   assign first_idx  = a1_ff;
   assign second_idx = a2_ff;
   assign first_wgt  = w1_ff;
   assign second_wgt = w2_ff;
   assign both_found = f1_ff & f2_ff;

endmodule

[rtl/huffman_code_lengths_unit.sv]
// Channel   Port     Direction  Moves
// request   req_if   in         symbol_freq, last_symbol
// response  rsp_if   out        symbol_index, code_length, path_length_sum, status,
//                               last_result
//
// Loading takes one cycle per symbol. For n symbols, merge k scans all n+k
// earlier nodes through the single read port of the weight memory, then
// passes ST_MERGE_END, ST_MERGE_W1 and ST_MERGE_W2 to pick and write back.
// The depth pass writes the root depth, then per node does a parent read, a
// depth read and a depth write. Each result passes ST_OUT_RD, then ST_OUT_LD.
// Reset is synchronous and clears control state only; no clearing pass is needed.
// A response stall holds ST_OUT_LD or ST_ERR; requests are taken only while loading.
module huffman_code_lengths_unit #(
   parameter int ALPHABET_SIZE = hcl_pkg::ALPHABET_SIZE_DEF,
   parameter int FREQ_BITS     = hcl_pkg::FREQ_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   hcl_req_if.sink   req_if,
   hcl_rsp_if.source rsp_if
);

   localparam int NODE_MAX = 2 * ALPHABET_SIZE - 1;
   localparam int NID_W    = $clog2(NODE_MAX);
   localparam int CNT_W    = $clog2(ALPHABET_SIZE + 1);
   localparam int WGT_W    = FREQ_BITS + $clog2(ALPHABET_SIZE);
   localparam int PROD_W   = FREQ_BITS + hcl_pkg::LEN_W;

   // Node stores
   logic [WGT_W-1:0]          wmem [NODE_MAX];
   logic [NID_W-1:0]          pmem [NODE_MAX];
   logic [hcl_pkg::LEN_W-1:0] dmem [NODE_MAX];

   hcl_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]          count_ff, count_in, n_ff, n_in;
   logic [1:0]                err_ff, err_in, err_acc;
   logic [NID_W-1:0]          id_ff, id_in, scan_ff, scan_in, c_ff, c_in;
   logic [CNT_W-1:0]          i_ff, i_in;
   logic [NODE_MAX-1:0]       live_ff, live_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic [NID_W-1:0]          rd_idx_ff, rd_idx_in;
   logic [hcl_pkg::SUM_W-1:0] acc_ff, acc_in;

   logic [WGT_W-1:0]          wmem_q_ff;
   logic [NID_W-1:0]          pmem_q_ff;
   logic [hcl_pkg::LEN_W-1:0] dmem_q_ff;

   logic                      w_we, p_we, d_we;
   logic [NID_W-1:0]          w_waddr, p_waddr, d_waddr, w_raddr, d_raddr;
   logic [WGT_W-1:0]          w_wdata;
   logic [hcl_pkg::LEN_W-1:0] d_wdata;

   logic                      trk_clear, trk_en, trk_both;
   logic [NID_W-1:0]          trk_a, trk_b;
   logic [WGT_W-1:0]          trk_wa, trk_wb;

   logic [NID_W:0]            two_n;
   logic [NID_W-1:0]          last_id;
   logic                      fin;
   logic [PROD_W-1:0]         prod;
   logic [hcl_pkg::SUM_W-1:0] sum_next;
   logic                      accept, rsp_free;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [hcl_pkg::SYM_W-1:0]     rsp_sym_ff, rsp_sym_in;
   logic [hcl_pkg::LEN_W-1:0]     rsp_len_ff, rsp_len_in;
   logic [hcl_pkg::SUM_W-1:0]     rsp_sum_ff, rsp_sum_in;
   logic [hcl_pkg::STATUS_W-1:0]  rsp_st_ff, rsp_st_in;
   logic                          rsp_last_ff, rsp_last_in;

   hcl_min2 #(
      .IDX_W (NID_W),
      .WGT_W (WGT_W)
   ) u_min2 (
      .clock      (clock),
      .reset      (reset),
      .clear      (trk_clear),
      .en         (trk_en),
      .idx        (rd_idx_ff),
      .weight     (wmem_q_ff),
      .first_idx  (trk_a),
      .second_idx (trk_b),
      .first_wgt  (trk_wa),
      .second_wgt (trk_wb),
      .both_found (trk_both)
   );

   assign two_n    = (NID_W + 1)'(n_ff) << 1;
   assign last_id  = NID_W'(two_n - (NID_W + 1)'(2));
   assign fin      = (i_ff == n_ff - CNT_W'(1));
   assign prod     = PROD_W'(wmem_q_ff[FREQ_BITS-1:0]) * PROD_W'(dmem_q_ff);
   assign sum_next = acc_ff + hcl_pkg::SUM_W'(prod);
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign accept   = req_if.valid && req_if.ready;
   assign trk_en   = rd_vld_ff && live_ff[rd_idx_ff];

   assign req_if.ready = (state_ff == hcl_pkg::ST_LOAD);

   // Error code after the incoming request
   always_comb begin
      err_acc = err_ff;
      if (count_ff < CNT_W'(ALPHABET_SIZE)) begin
         if (req_if.symbol_freq == '0 && err_ff == hcl_pkg::STATUS_OK)
            err_acc = hcl_pkg::STATUS_ZERO_FREQ;
      end else if (err_ff == hcl_pkg::STATUS_OK) begin
         err_acc = hcl_pkg::STATUS_OVERFLOW;
      end
   end

   // Sequencer: next state, memory controls and response load
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      err_in      = err_ff;
      n_in        = n_ff;
      id_in       = id_ff;
      scan_in     = scan_ff;
      c_in        = c_ff;
      i_in        = i_ff;
      live_in     = live_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = rd_idx_ff;
      acc_in      = acc_ff;
      trk_clear   = 1'b0;
      w_we        = 1'b0;
      p_we        = 1'b0;
      d_we        = 1'b0;
      w_waddr     = NID_W'(count_ff);
      w_wdata     = WGT_W'(req_if.symbol_freq);
      p_waddr     = trk_a;
      d_waddr     = c_ff;
      d_wdata     = dmem_q_ff + hcl_pkg::LEN_W'(1);
      w_raddr     = scan_ff;
      d_raddr     = pmem_q_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_sym_in  = rsp_sym_ff;
      rsp_len_in  = rsp_len_ff;
      rsp_sum_in  = rsp_sum_ff;
      rsp_st_in   = rsp_st_ff;
      rsp_last_in = rsp_last_ff;

      case (state_ff)
         hcl_pkg::ST_LOAD: begin
            if (accept) begin
               err_in = err_acc;
               if (count_ff < CNT_W'(ALPHABET_SIZE)) begin
                  w_we     = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_if.last_symbol) begin
                  count_in  = '0;
                  n_in      = (count_ff < CNT_W'(ALPHABET_SIZE)) ?
                              count_ff + CNT_W'(1) : count_ff;
                  id_in     = NID_W'(n_in);
                  scan_in   = '0;
                  acc_in    = '0;
                  i_in      = '0;
                  trk_clear = 1'b1;
                  for (int k = 0; k < NODE_MAX; k++)
                     live_in[k] = (k < int'(n_in));
                  if (err_acc != hcl_pkg::STATUS_OK)
                     state_in = hcl_pkg::ST_ERR;
                  else if (n_in == CNT_W'(1))
                     state_in = hcl_pkg::ST_DEPTH_ROOT;
                  else
                     state_in = hcl_pkg::ST_MERGE_SCAN;
               end
            end
         end
         hcl_pkg::ST_MERGE_SCAN: begin
            // Issue one weight read per cycle over all earlier nodes
            rd_vld_in = 1'b1;
            rd_idx_in = scan_ff;
            scan_in   = scan_ff + NID_W'(1);
            if (scan_ff == id_ff - NID_W'(1))
               state_in = hcl_pkg::ST_MERGE_END;
         end
         hcl_pkg::ST_MERGE_END: begin
            state_in = hcl_pkg::ST_MERGE_W1;
         end
         hcl_pkg::ST_MERGE_W1: begin
            w_we           = 1'b1;
            w_waddr        = id_ff;
            w_wdata        = trk_wa + trk_wb;
            p_we           = 1'b1;
            p_waddr        = trk_a;
            live_in[trk_a] = 1'b0;
            state_in       = hcl_pkg::ST_MERGE_W2;
         end
         hcl_pkg::ST_MERGE_W2: begin
            p_we           = 1'b1;
            p_waddr        = trk_b;
            live_in[trk_b] = 1'b0;
            live_in[id_ff] = 1'b1;
            trk_clear      = 1'b1;
            scan_in        = '0;
            id_in          = id_ff + NID_W'(1);
            if (id_ff == last_id)
               state_in = hcl_pkg::ST_DEPTH_ROOT;
            else
               state_in = hcl_pkg::ST_MERGE_SCAN;
         end
         hcl_pkg::ST_DEPTH_ROOT: begin
            d_we    = 1'b1;
            d_waddr = last_id;
            d_wdata = '0;
            c_in    = last_id - NID_W'(1);
            if (last_id == '0)
               state_in = hcl_pkg::ST_OUT_RD;
            else
               state_in = hcl_pkg::ST_DEPTH_P;
         end
         hcl_pkg::ST_DEPTH_P: begin
            state_in = hcl_pkg::ST_DEPTH_D;
         end
         hcl_pkg::ST_DEPTH_D: begin
            d_raddr  = pmem_q_ff;
            state_in = hcl_pkg::ST_DEPTH_W;
         end
         hcl_pkg::ST_DEPTH_W: begin
            d_we = 1'b1;
            c_in = c_ff - NID_W'(1);
            if (c_ff == '0)
               state_in = hcl_pkg::ST_OUT_RD;
            else
               state_in = hcl_pkg::ST_DEPTH_P;
         end
         hcl_pkg::ST_OUT_RD: begin
            w_raddr  = NID_W'(i_ff);
            d_raddr  = NID_W'(i_ff);
            state_in = hcl_pkg::ST_OUT_LD;
         end
         hcl_pkg::ST_OUT_LD: begin
            // Hold read data until the response register frees up
            w_raddr = NID_W'(i_ff);
            d_raddr = NID_W'(i_ff);
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_sym_in   = hcl_pkg::SYM_W'(i_ff);
               rsp_len_in   = dmem_q_ff;
               rsp_sum_in   = fin ? sum_next : '0;
               rsp_st_in    = hcl_pkg::STATUS_OK;
               rsp_last_in  = fin;
               acc_in       = sum_next;
               i_in         = i_ff + CNT_W'(1);
               state_in     = fin ? hcl_pkg::ST_LOAD : hcl_pkg::ST_OUT_RD;
            end
         end
         hcl_pkg::ST_ERR: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_sym_in   = '0;
               rsp_len_in   = '0;
               rsp_sum_in   = '0;
               rsp_st_in    = err_ff;
               rsp_last_in  = 1'b1;
               err_in       = hcl_pkg::STATUS_OK;
               state_in     = hcl_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = hcl_pkg::ST_LOAD;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hcl_pkg::ST_LOAD;
         count_ff     <= '0;
         err_ff       <= hcl_pkg::STATUS_OK;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      id_ff       <= id_in;
      scan_ff     <= scan_in;
      c_ff        <= c_in;
      i_ff        <= i_in;
      live_ff     <= live_in;
      rd_idx_ff   <= rd_idx_in;
      acc_ff      <= acc_in;
      rsp_sym_ff  <= rsp_sym_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Node memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (w_we)
         wmem[w_waddr] <= w_wdata;
      wmem_q_ff <= wmem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (p_we)
         pmem[p_waddr] <= id_ff;
      pmem_q_ff <= pmem[c_ff];
   end

   always_ff @(posedge clock) begin
      if (d_we)
         dmem[d_waddr] <= d_wdata;
      dmem_q_ff <= dmem[d_raddr];
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.symbol_index    = rsp_sym_ff;
   assign rsp_if.code_length     = rsp_len_ff;
   assign rsp_if.path_length_sum = rsp_sum_ff;
   assign rsp_if.status          = rsp_st_ff;
   assign rsp_if.last_result     = rsp_last_ff;

   // Load count never passes the alphabet size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ALPHABET_SIZE))
      else $error("load count out of range");

   // A merge always has two distinct live children
   a_merge_pair: assert property (@(posedge clock) disable iff (reset)
      state_ff == hcl_pkg::ST_MERGE_W1 |->
         trk_both && trk_a != trk_b && live_ff[trk_a] && live_ff[trk_b])
      else $error("merge without two live nodes");

   // Parents sit above their children in the node store
   a_parent_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == hcl_pkg::ST_DEPTH_W |-> pmem_q_ff > c_ff)
      else $error("parent index not above child");

   // The merged node is always the next one after the scan range
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == hcl_pkg::ST_MERGE_END |-> $past(scan_ff) == id_ff - NID_W'(1))
      else $error("scan ended early");

endmodule

[tb/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSYM = hcl_pkg::ALPHABET_SIZE_DEF;
   localparam int FW   = hcl_pkg::FREQ_BITS_DEF;

   typedef struct packed {
      logic [hcl_pkg::SYM_W-1:0]    sym;
      logic [hcl_pkg::LEN_W-1:0]    len;
      logic [hcl_pkg::SUM_W-1:0]    wpl;
      logic [hcl_pkg::STATUS_W-1:0] status;
      logic                         last;
   } code_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hcl_req_if #(.FREQ_BITS(FW)) req_if ();
   hcl_rsp_if rsp_if ();

   huffman_code_lengths_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   // Predictor state: loaded alphabet and held error
   logic [FW-1:0]                leaf_freq [NSYM];
   int unsigned                  n_loaded = 0;
   logic [hcl_pkg::STATUS_W-1:0] err_held = hcl_pkg::STATUS_OK;

   code_rsp_type expected_codes[$];
   int           n_fail = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   bit           recv_hold = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Build the tree with earliest-created tie-break and queue one result per symbol
   task automatic predict_codes();
      logic [35:0]  wt [2*NSYM-1];
      int           par [2*NSYM-1];
      int           dep [2*NSYM-1];
      bit           live [2*NSYM-1];
      int           a, b, id;
      logic [63:0]  sum;
      code_rsp_type r;
      sum = 0;
      for (int i = 0; i < 2*NSYM-1; i++) live[i] = 1'b0;
      for (int i = 0; i < n_loaded; i++) begin
         wt[i] = 36'(leaf_freq[i]);
         live[i] = 1'b1;
      end
      for (int k = 0; k + 1 < n_loaded; k++) begin
         id = n_loaded + k;
         a = -1;
         for (int i = 0; i < id; i++)
            if (live[i] && (a < 0 || wt[i] < wt[a])) a = i;
         live[a] = 1'b0;
         b = -1;
         for (int i = 0; i < id; i++)
            if (live[i] && (b < 0 || wt[i] < wt[b])) b = i;
         live[b] = 1'b0;
         wt[id] = wt[a] + wt[b];
         par[a] = id;
         par[b] = id;
         live[id] = 1'b1;
      end
      dep[2*n_loaded-2] = 0;
      for (int i = 2*n_loaded-2; i > 0; i--) dep[i-1] = (dep[par[i-1]] + 1) & 63;
      for (int i = 0; i < n_loaded; i++) sum += 64'(leaf_freq[i]) * 64'(dep[i]);
      for (int i = 0; i < n_loaded; i++) begin
         r.sym    = hcl_pkg::SYM_W'(i);
         r.len    = hcl_pkg::LEN_W'(dep[i]);
         r.wpl    = (i + 1 == n_loaded) ? sum[hcl_pkg::SUM_W-1:0] : '0;
         r.status = hcl_pkg::STATUS_OK;
         r.last   = (i + 1 == n_loaded);
         expected_codes.push_back(r);
      end
   endtask

   // Advance predictor by one accepted request
   task automatic absorb_symbol(input logic [FW-1:0] f, input logic lst);
      code_rsp_type r;
      if (n_loaded < NSYM) begin
         leaf_freq[n_loaded] = f;
         n_loaded++;
         if (f == 0 && err_held == hcl_pkg::STATUS_OK) err_held = hcl_pkg::STATUS_ZERO_FREQ;
      end else if (err_held == hcl_pkg::STATUS_OK) begin
         err_held = hcl_pkg::STATUS_OVERFLOW;
      end
      if (!lst) return;
      if (err_held != hcl_pkg::STATUS_OK) begin
         r = '0;
         r.status = err_held;
         r.last = 1'b1;
         expected_codes.push_back(r);
      end else begin
         predict_codes();
      end
      n_loaded = 0;
      err_held = hcl_pkg::STATUS_OK;
   endtask

   // Drive one request and hold until accepted; valid stays up for the next one
   task automatic send_symbol(input logic [FW-1:0] f, input logic lst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.symbol_freq <= f;
      req_if.last_symbol <= lst;
      do @(posedge clock); while (!req_if.ready);
      absorb_symbol(f, lst);
   endtask

   // Drop valid once a sequence of requests is done
   task automatic stop_sending();
      req_if.valid <= 1'b0;
   endtask

   task automatic send_alphabet(input int n, input bit skewed);
      logic [FW-1:0] f;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: f = FW'($urandom_range(8, 1));
            1: f = skewed ? (24'd1 << $urandom_range(23)) : FW'($urandom_range(100, 1));
            default: f = FW'($urandom_range(24'hFFFFFF, 1));
         endcase
         send_symbol(f, i == n-1);
      end
   endtask

   task automatic wait_drained();
      while (expected_codes.size() != 0) @(posedge clock);
   endtask

   // Extremes, ties, single symbol, error cases
   task automatic test_directed();
      send_symbol(24'd5, 1'b1);
      send_symbol(24'hFFFFFF, 1'b0);
      send_symbol(24'hFFFFFF, 1'b1);
      for (int i = 0; i < 4; i++) send_symbol(24'd7, i == 3);
      send_symbol(24'd1, 1'b0);
      send_symbol(24'd0, 1'b0);
      send_symbol(24'd3, 1'b1);
      send_symbol(24'd0, 1'b1);
      send_symbol(24'h800000, 1'b0);
      send_symbol(24'h7FFFFF, 1'b0);
      send_symbol(24'h555555, 1'b0);
      send_symbol(24'hAAAAAA, 1'b1);
      stop_sending();
      wait_drained();
   endtask

   // Full alphabet of maximum weights, then one too many
   task automatic test_full_alphabet();
      for (int i = 0; i < NSYM; i++) send_symbol(24'hFFFFFF, i == NSYM-1);
      stop_sending();
      wait_drained();
      for (int i = 0; i <= NSYM; i++) send_symbol(FW'(i + 1), i == NSYM);
      stop_sending();
      wait_drained();
   endtask

   // Random alphabets with some broken ones
   task automatic test_random(input int items);
      int sent, n;
      sent = 0;
      while (sent < items) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(12, 1);
         if ($urandom_range(7) == 0) begin
            for (int i = 0; i < n; i++)
               send_symbol((i == n/2) ? '0 : FW'($urandom), i == n-1);
         end else begin
            send_alphabet(n, $urandom_range(1));
         end
         sent += n;
      end
      stop_sending();
      wait_drained();
   endtask

   // Hold the receiver while the sender keeps going
   task automatic test_backpressure();
      recv_hold = 1'b1;
      fork
         begin
            send_alphabet(6, 1'b0);
            send_alphabet(5, 1'b0);
            stop_sending();
         end
         begin
            repeat (400) @(posedge clock);
            recv_hold = 1'b0;
         end
      join
      wait_drained();
   endtask

   // Receiver ready with random stalls
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare each response with the oldest prediction
   always @(posedge clock) begin
      code_rsp_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_codes.size() == 0) begin
            $error("unexpected response sym=%0d", rsp_if.symbol_index);
            n_fail++;
         end else begin
            e = expected_codes.pop_front();
            if (rsp_if.symbol_index !== e.sym) begin
               $error("symbol_index exp %0d got %0d", e.sym, rsp_if.symbol_index);
               n_fail++;
            end
            if (rsp_if.code_length !== e.len) begin
               $error("code_length exp %0d got %0d", e.len, rsp_if.code_length);
               n_fail++;
            end
            if (rsp_if.path_length_sum !== e.wpl) begin
               $error("path_length_sum exp %0d got %0d", e.wpl, rsp_if.path_length_sum);
               n_fail++;
            end
            if (rsp_if.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_if.status);
               n_fail++;
            end
            if (rsp_if.last_result !== e.last) begin
               $error("last_result exp %0d got %0d", e.last, rsp_if.last_result);
               n_fail++;
            end
         end
      end
   end

   initial begin
      req_if.valid       <= 1'b0;
      req_if.symbol_freq <= '0;
      req_if.last_symbol <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_alphabet();
      send_idle_pct = 26; recv_idle_pct = 56;
      test_random(15);
      send_idle_pct = 56; recv_idle_pct = 26;
      test_random(15);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(15);
      test_backpressure();
      repeat (50) @(posedge clock);
      if (n_fail == 0 && expected_codes.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule
